// File: rtl/idd_pkg.sv
// idd_pkg: shared constants, types, FSM encoding and command/status structs
// for the isotropic diffusion denoiser. Depends on nothing.
package idd_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int FRAC_BITS  = 8;
  localparam int PIX_BITS   = 8;
  localparam int MIN_DIM    = 3;

  localparam int VAL_W      = PIX_BITS + FRAC_BITS;      // stored 8.8 pixel
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int RAM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int POS_W      = $clog2(RAM_DEPTH);
  localparam int CNT_W      = POS_W + 1;
  localparam int DIM_W      = 10;                         // size register width
  localparam int KAPPA_W    = 16;
  localparam int ITER_W     = 16;
  localparam int CFG_W      = 16;
  localparam int GAIN_SHIFT = 16;                         // kappa is 0.16

  localparam int TAPS       = 4;                          // neighbours in stencil
  localparam int TAP_SHIFT  = $clog2(TAPS);
  localparam int SUM_W      = VAL_W + TAP_SHIFT;
  localparam int LAP_W      = SUM_W + 1;
  localparam int PROD_W     = KAPPA_W + 1 + LAP_W;
  localparam int DELTA_W    = PROD_W - GAIN_SHIFT;
  localparam int DIV_CNT_W  = $clog2(POS_W);

  // stencil read sequence
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] TAP_U    = 3'd0;
  localparam logic [STEP_W-1:0] TAP_N    = 3'd1;
  localparam logic [STEP_W-1:0] TAP_S    = 3'd2;
  localparam logic [STEP_W-1:0] TAP_W    = 3'd3;
  localparam logic [STEP_W-1:0] TAP_E    = 3'd4;
  localparam logic [STEP_W-1:0] TAP_LAST = 3'd5;

  // configuration register indexes
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_KAPPA  = 2'd0;
  localparam reg_idx_t REG_ITERS  = 2'd1;
  localparam reg_idx_t REG_WIDTH  = 2'd2;
  localparam reg_idx_t REG_HEIGHT = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_PRD  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_WR   = 5'b10000
  } state_t;

  typedef struct packed {
    logic load_go;
    logic read_go;
    logic div_start;
    logic div_step;
    logic rd_go;
    logic mul_go;
    logic wr_go;
  } cmd_t;

  typedef struct packed {
    logic ld_done;
    logic iters_zero;
    logic out_block;
    logic div_done;
    logic rd_last;
    logic px_last;
    logic pass_last;
  } stat_t;

endpackage

// File: rtl/idd_ram.sv
// idd_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module idd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/idd_ctrl.sv
// idd_ctrl: sequencer for load/read words, position resync and diffusion passes.
// Depends on idd_pkg.
module idd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_stall,
  input  logic              cfg_we,
  input  idd_pkg::reg_idx_t cfg_index,
  input  idd_pkg::stat_t    stat,
  output idd_pkg::cmd_t     cmd
);

  idd_pkg::state_t state_r, state_nxt;
  logic idle, in_fire, size_wr;

  assign idle     = (state_r == idd_pkg::ST_IDLE);
  assign in_stall = !idle || stat.out_block;
  assign in_fire  = in_valid && !in_stall;
  assign size_wr  = cfg_we && ((cfg_index == idd_pkg::REG_WIDTH) ||
                               (cfg_index == idd_pkg::REG_HEIGHT));

  always_comb begin
    cmd.load_go   = in_fire && !in_command;
    cmd.read_go   = in_fire && in_command;
    cmd.div_start = idle && size_wr;
    cmd.div_step  = (state_r == idd_pkg::ST_DIV);
    cmd.rd_go     = (state_r == idd_pkg::ST_PRD);
    cmd.mul_go    = (state_r == idd_pkg::ST_MUL);
    cmd.wr_go     = (state_r == idd_pkg::ST_WR);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      idd_pkg::ST_IDLE: begin
        if (cmd.div_start) begin
          state_nxt = idd_pkg::ST_DIV;
        end else if (cmd.load_go && stat.ld_done && !stat.iters_zero) begin
          state_nxt = idd_pkg::ST_PRD;
        end
      end
      idd_pkg::ST_DIV: begin
        if (stat.div_done) state_nxt = idd_pkg::ST_IDLE;
      end
      idd_pkg::ST_PRD: begin
        if (stat.rd_last) state_nxt = idd_pkg::ST_MUL;
      end
      idd_pkg::ST_MUL: state_nxt = idd_pkg::ST_WR;
      idd_pkg::ST_WR: begin
        state_nxt = (stat.px_last && stat.pass_last) ? idd_pkg::ST_IDLE
                                                     : idd_pkg::ST_PRD;
      end
      default: state_nxt = idd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= idd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/idd_dp.sv
// idd_dp: config registers, position counters, resync divider, stencil
// arithmetic and output register. Depends on idd_pkg; drives two idd_ram.
module idd_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  idd_pkg::cmd_t                     cmd,
  output idd_pkg::stat_t                    stat,
  input  logic                              cfg_we,
  input  idd_pkg::reg_idx_t                 cfg_index,
  input  logic [idd_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic [idd_pkg::PIX_BITS-1:0]      in_pixel_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [idd_pkg::PIX_BITS-1:0]      out_pixel_out,
  output logic                              out_last_pixel,
  output logic                              ram0_we,
  output logic                              ram1_we,
  output logic [idd_pkg::ADDR_W-1:0]        ram_waddr,
  output logic [idd_pkg::VAL_W-1:0]         ram_wdata,
  output logic                              ram_re,
  output logic [idd_pkg::ADDR_W-1:0]        ram_raddr,
  input  logic [idd_pkg::VAL_W-1:0]         ram0_rdata,
  input  logic [idd_pkg::VAL_W-1:0]         ram1_rdata
);

  localparam int DIM_W = idd_pkg::DIM_W;
  localparam int POS_W = idd_pkg::POS_W;
  localparam int CNT_W = idd_pkg::CNT_W;
  localparam int ROW_W = idd_pkg::ROW_W;
  localparam int COL_W = idd_pkg::COL_W;
  localparam int VAL_W = idd_pkg::VAL_W;

  // config
  logic [idd_pkg::KAPPA_W-1:0] kappa_r;
  logic [idd_pkg::ITER_W-1:0]  iters_r;
  logic [DIM_W-1:0]            width_r, height_r, w_use, h_use;
  logic [CNT_W-1:0]            count_r;

  // positions
  logic [POS_W-1:0] ld_pos_r, rd_pos_r, ld_eff_pos, rd_eff_pos;
  logic [ROW_W-1:0] ld_row_r, rd_row_r, ld_eff_row, rd_eff_row;
  logic [COL_W-1:0] ld_col_r, rd_col_r, ld_eff_col, rd_eff_col;
  logic [CNT_W-1:0] ld_nxt_pos;
  logic             ld_wr, ld_col_wrap, rd_wrap, rd_last, rd_act, rd_col_wrap;
  logic             res_rdy_r, cur_r, rsel_r;

  // pass
  logic [idd_pkg::ITER_W-1:0]  iter_r;
  logic [ROW_W-1:0]            prow_r;
  logic [COL_W-1:0]            pcol_r;
  logic [idd_pkg::STEP_W-1:0]  step_r;
  logic [VAL_W-1:0]            u_r, rdata_sel, vsat;
  logic [idd_pkg::SUM_W-1:0]   sum_r;
  logic signed [idd_pkg::LAP_W-1:0]   lap;
  logic signed [idd_pkg::PROD_W-1:0]  prod_r;
  logic signed [idd_pkg::DELTA_W-1:0] delta;
  logic signed [idd_pkg::DELTA_W:0]   vsum;
  logic [idd_pkg::ADDR_W-1:0]  pass_raddr;
  logic                        pcol_last, prow_last;

  // divider
  logic [POS_W-1:0]                dvd_r, dvd_nxt;
  logic [DIM_W-1:0]                rem_r, rem_nxt;
  logic [DIM_W:0]                  div_try;
  logic                            div_ge, div_sel_r, div_end;
  logic [idd_pkg::DIV_CNT_W-1:0]   div_cnt_r;

  // output
  logic                          rd_pend_r, last_pend_r, out_valid_r, out_last_r, xfer;
  logic [idd_pkg::PIX_BITS-1:0]  out_pixel_r;

  always_comb begin
    if (width_r < DIM_W'(idd_pkg::MIN_DIM))        w_use = DIM_W'(idd_pkg::MIN_DIM);
    else if (width_r > DIM_W'(idd_pkg::MAX_WIDTH)) w_use = DIM_W'(idd_pkg::MAX_WIDTH);
    else                                           w_use = width_r;
    if (height_r < DIM_W'(idd_pkg::MIN_DIM))         h_use = DIM_W'(idd_pkg::MIN_DIM);
    else if (height_r > DIM_W'(idd_pkg::MAX_HEIGHT)) h_use = DIM_W'(idd_pkg::MAX_HEIGHT);
    else                                             h_use = height_r;
  end

  // load side
  assign ld_eff_pos  = res_rdy_r ? '0 : ld_pos_r;
  assign ld_eff_row  = res_rdy_r ? '0 : ld_row_r;
  assign ld_eff_col  = res_rdy_r ? '0 : ld_col_r;
  assign ld_nxt_pos  = {1'b0, ld_eff_pos} + CNT_W'(1);
  assign ld_wr       = cmd.load_go && ({1'b0, ld_eff_pos} < count_r);
  assign ld_col_wrap = (({1'b0, ld_eff_col} + DIM_W'(1)) == w_use);

  // read side
  assign rd_wrap     = ({1'b0, rd_pos_r} >= count_r);
  assign rd_eff_pos  = rd_wrap ? '0 : rd_pos_r;
  assign rd_eff_row  = rd_wrap ? '0 : rd_row_r;
  assign rd_eff_col  = rd_wrap ? '0 : rd_col_r;
  assign rd_last     = ({1'b0, rd_eff_pos} == (count_r - CNT_W'(1)));
  assign rd_act      = cmd.read_go && res_rdy_r;
  assign rd_col_wrap = (({1'b0, rd_eff_col} + DIM_W'(1)) == w_use);

  // stencil addressing
  always_comb begin
    unique case (step_r)
      idd_pkg::TAP_N: pass_raddr = {prow_r - ROW_W'(1), pcol_r};
      idd_pkg::TAP_S: pass_raddr = {prow_r + ROW_W'(1), pcol_r};
      idd_pkg::TAP_W: pass_raddr = {prow_r, pcol_r - COL_W'(1)};
      idd_pkg::TAP_E: pass_raddr = {prow_r, pcol_r + COL_W'(1)};
      default:        pass_raddr = {prow_r, pcol_r};
    endcase
  end

  assign ram_re    = rd_act || (cmd.rd_go && (step_r != idd_pkg::TAP_LAST));
  assign ram_raddr = rd_act ? {rd_eff_row, rd_eff_col} : pass_raddr;
  assign rdata_sel = rsel_r ? ram1_rdata : ram0_rdata;

  // u + floor(kappa*lap / 2^16), clipped to the 8.8 range
  assign lap   = $signed({1'b0, sum_r}) -
                 $signed({1'b0, u_r, {idd_pkg::TAP_SHIFT{1'b0}}});
  assign delta = prod_r[idd_pkg::PROD_W-1:idd_pkg::GAIN_SHIFT];
  assign vsum  = $signed({{(idd_pkg::DELTA_W+1-VAL_W){1'b0}}, u_r}) +
                 $signed({delta[idd_pkg::DELTA_W-1], delta});
  always_comb begin
    if (vsum[idd_pkg::DELTA_W])                 vsat = '0;
    else if (|vsum[idd_pkg::DELTA_W-1:VAL_W])   vsat = '1;
    else                                        vsat = vsum[VAL_W-1:0];
  end

  assign pcol_last = (({1'b0, pcol_r} + DIM_W'(2)) == w_use);
  assign prow_last = (({1'b0, prow_r} + DIM_W'(2)) == h_use);

  // writes: a load goes to both frames, a pass to the one not being read
  assign ram0_we   = ld_wr || (cmd.wr_go && cur_r);
  assign ram1_we   = ld_wr || (cmd.wr_go && !cur_r);
  assign ram_waddr = ld_wr ? {ld_eff_row, ld_eff_col} : {prow_r, pcol_r};
  assign ram_wdata = ld_wr ? {in_pixel_in, {idd_pkg::FRAC_BITS{1'b0}}} : vsat;

  // restoring divider step: position -> row, col
  assign div_try = {rem_r, dvd_r[POS_W-1]};
  assign div_ge  = (div_try >= {1'b0, w_use});
  assign rem_nxt = div_ge ? DIM_W'(div_try - {1'b0, w_use}) : div_try[DIM_W-1:0];
  assign dvd_nxt = {dvd_r[POS_W-2:0], div_ge};
  assign div_end = (div_cnt_r == idd_pkg::DIV_CNT_W'(POS_W - 1));

  assign xfer = rd_pend_r && (!out_valid_r || !out_stall);

  always_comb begin
    stat.ld_done    = (ld_nxt_pos >= count_r);
    stat.iters_zero = (iters_r == '0);
    stat.out_block  = rd_pend_r && !xfer;
    stat.div_done   = cmd.div_step && div_end && div_sel_r;
    stat.rd_last    = (step_r == idd_pkg::TAP_LAST);
    stat.px_last    = pcol_last && prow_last;
    stat.pass_last  = (iter_r == idd_pkg::ITER_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kappa_r     <= idd_pkg::KAPPA_W'(6554);
      iters_r     <= idd_pkg::ITER_W'(1);
      width_r     <= DIM_W'(idd_pkg::MAX_WIDTH);
      height_r    <= DIM_W'(idd_pkg::MAX_HEIGHT);
      ld_pos_r    <= '0;
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      rd_pos_r    <= '0;
      rd_row_r    <= '0;
      rd_col_r    <= '0;
      res_rdy_r   <= 1'b0;
      cur_r       <= 1'b0;
      rsel_r      <= 1'b0;
      iter_r      <= '0;
      prow_r      <= ROW_W'(1);
      pcol_r      <= COL_W'(1);
      step_r      <= idd_pkg::TAP_U;
      div_sel_r   <= 1'b0;
      div_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
      last_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          idd_pkg::REG_KAPPA:  kappa_r  <= cfg_wdata[idd_pkg::KAPPA_W-1:0];
          idd_pkg::REG_ITERS:  iters_r  <= cfg_wdata[idd_pkg::ITER_W-1:0];
          idd_pkg::REG_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
          idd_pkg::REG_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
          default: ;
        endcase
      end

      if (cmd.load_go) begin
        res_rdy_r <= 1'b0;
        if (ld_eff_pos == '0) cur_r <= 1'b0;
        if (stat.ld_done) begin
          ld_pos_r <= '0;
          ld_row_r <= '0;
          ld_col_r <= '0;
          rd_pos_r <= '0;
          rd_row_r <= '0;
          rd_col_r <= '0;
          iter_r   <= iters_r;
          prow_r   <= ROW_W'(1);
          pcol_r   <= COL_W'(1);
          step_r   <= idd_pkg::TAP_U;
          if (stat.iters_zero) res_rdy_r <= 1'b1;
        end else begin
          ld_pos_r <= ld_nxt_pos[POS_W-1:0];
          if (ld_col_wrap) begin
            ld_col_r <= '0;
            ld_row_r <= ld_eff_row + ROW_W'(1);
          end else begin
            ld_col_r <= ld_eff_col + COL_W'(1);
            ld_row_r <= ld_eff_row;
          end
        end
      end

      if (ram_re) rsel_r <= cur_r;

      if (rd_act) begin
        if (rd_last) begin
          rd_pos_r <= '0;
          rd_row_r <= '0;
          rd_col_r <= '0;
        end else begin
          rd_pos_r <= rd_eff_pos + POS_W'(1);
          if (rd_col_wrap) begin
            rd_col_r <= '0;
            rd_row_r <= rd_eff_row + ROW_W'(1);
          end else begin
            rd_col_r <= rd_eff_col + COL_W'(1);
            rd_row_r <= rd_eff_row;
          end
        end
      end

      if (cmd.rd_go) begin
        step_r <= stat.rd_last ? idd_pkg::TAP_U : step_r + idd_pkg::STEP_W'(1);
      end

      if (cmd.wr_go) begin
        if (stat.px_last) begin
          prow_r <= ROW_W'(1);
          pcol_r <= COL_W'(1);
          cur_r  <= !cur_r;
          iter_r <= iter_r - idd_pkg::ITER_W'(1);
          if (stat.pass_last) res_rdy_r <= 1'b1;
        end else if (pcol_last) begin
          pcol_r <= COL_W'(1);
          prow_r <= prow_r + ROW_W'(1);
        end else begin
          pcol_r <= pcol_r + COL_W'(1);
        end
      end

      if (cmd.div_start) begin
        div_sel_r <= 1'b0;
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        if (div_end) begin
          div_cnt_r <= '0;
          div_sel_r <= 1'b1;
          if (!div_sel_r) begin
            ld_row_r <= dvd_nxt[ROW_W-1:0];
            ld_col_r <= rem_nxt[COL_W-1:0];
          end else begin
            rd_row_r <= dvd_nxt[ROW_W-1:0];
            rd_col_r <= rem_nxt[COL_W-1:0];
          end
        end else begin
          div_cnt_r <= div_cnt_r + idd_pkg::DIV_CNT_W'(1);
        end
      end

      // RAM read data waits in rd_pend until the output register frees up
      if (rd_act)    rd_pend_r <= 1'b1;
      else if (xfer) rd_pend_r <= 1'b0;
      if (rd_act)    last_pend_r <= rd_last;
      if (xfer)                           out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    count_r <= CNT_W'(w_use) * CNT_W'(h_use);
    if (cmd.div_start) begin
      dvd_r <= ld_pos_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (div_end && !div_sel_r) begin
        dvd_r <= rd_pos_r;
        rem_r <= '0;
      end else begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
      end
    end
    if (cmd.rd_go && (step_r != idd_pkg::TAP_U)) begin
      if (step_r == idd_pkg::TAP_N)      u_r   <= rdata_sel;
      else if (step_r == idd_pkg::TAP_S) sum_r <= idd_pkg::SUM_W'(rdata_sel);
      else                               sum_r <= sum_r + idd_pkg::SUM_W'(rdata_sel);
    end
    if (cmd.mul_go) prod_r <= $signed({1'b0, kappa_r}) * lap;
    if (xfer) begin
      out_pixel_r <= rdata_sel[VAL_W-1:idd_pkg::FRAC_BITS];
      out_last_r  <= last_pend_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pixel_r;
  assign out_last_pixel = out_last_r;

endmodule

// File: rtl/isotropic_diffusion_denoise.sv
// isotropic_diffusion_denoise: top level; controller, datapath and two frame RAMs.
// Depends on idd_pkg, idd_ram, idd_ctrl, idd_dp.
//
// Greyscale denoiser. Load words (command 0) stream an image in raster order,
// one 8-bit pixel per cycle while in_stall is low, into two 512x512 frames of
// 8.8 fixed point. The word that completes the image starts the configured
// number of passes of the five-point stencil u += kappa*(N+S+E+W-4u) over the
// interior; borders keep their loaded values. Each interior pixel takes five
// reads from the single read port of the source frame, one multiply and one
// write, with in_stall high throughout a pass. Read words (command 1) then
// return one result pixel per cycle while in_stall and out_stall are low,
// truncated to 8 bits, with out_last_pixel on the final one; reading wraps
// and may repeat. A read word before any result exists returns nothing.
// Writing the width or height register while idle re-derives the row/column
// of the load and read positions with a bit-serial divider, with in_stall high.
// Frame RAM contents are undefined until loaded.
module isotropic_diffusion_denoise (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [idd_pkg::PIX_BITS-1:0] in_pixel_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [idd_pkg::PIX_BITS-1:0] out_pixel_out,
  output logic                         out_last_pixel,
  input  logic                         cfg_we,
  input  idd_pkg::reg_idx_t            cfg_index,
  input  logic [idd_pkg::CFG_W-1:0]    cfg_wdata
);

  idd_pkg::cmd_t  cmd;
  idd_pkg::stat_t stat;

  logic                       ram0_we, ram1_we, ram_re;
  logic [idd_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [idd_pkg::VAL_W-1:0]  ram_wdata, ram0_rdata, ram1_rdata;

  idd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .stat       (stat),
    .cmd        (cmd)
  );

  idd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_last_pixel (out_last_pixel),
    .ram0_we        (ram0_we),
    .ram1_we        (ram1_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram0_rdata     (ram0_rdata),
    .ram1_rdata     (ram1_rdata)
  );

  // frame 0
  idd_ram #(.WIDTH(idd_pkg::VAL_W), .DEPTH(idd_pkg::RAM_DEPTH)) u_frame0 (
    .clk   (clk),
    .we    (ram0_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram0_rdata)
  );

  // frame 1
  idd_ram #(.WIDTH(idd_pkg::VAL_W), .DEPTH(idd_pkg::RAM_DEPTH)) u_frame1 (
    .clk   (clk),
    .we    (ram1_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram1_rdata)
  );

endmodule
